### rtl/fusc_pkg.sv
// Shared types and constants for the firmware upload session checker.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fusc_pkg;

   localparam int unsigned CHUNK_MAX      = 1024;
   localparam int unsigned SIZE_WIDTH     = 24;
   localparam int unsigned LEN_WIDTH      = 11;
   localparam int unsigned CSR_ADDR_WIDTH = 3;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [SIZE_WIDTH-1:0] MIN_SIZE_RESET = 24'h01_0000;
   localparam logic [SIZE_WIDTH-1:0] MAX_SIZE_RESET = 24'h10_0000;

   typedef enum logic [2:0] {
      KIND_BEGIN  = 3'd0,
      KIND_HEADER = 3'd1,
      KIND_BYTE   = 3'd2,
      KIND_END    = 3'd3,
      KIND_ABORT  = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_BEGIN_OK   = 4'd0,
      ST_BYTE_OK    = 4'd1,
      ST_CHUNK_OK   = 4'd2,
      ST_COMPLETE   = 4'd3,
      ST_ABORTED    = 4'd4,
      ST_SIZE       = 4'd5,
      ST_NOBEGIN    = 4'd6,
      ST_OFFSET     = 4'd7,
      ST_LENGTH     = 4'd8,
      ST_OVERFLOW   = 4'd9,
      ST_INCOMPLETE = 4'd10,
      ST_CRC        = 4'd11,
      ST_STRAY      = 4'd12
   } status_type;

   typedef enum logic {
      CSR_MIN_IMAGE_SIZE = 1'b0,
      CSR_MAX_IMAGE_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]           kind;
      logic [31:0]          value;
      logic [LEN_WIDTH-1:0] chunk_length;
      logic [7:0]           data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]            status;
      logic [31:0]           report_value;
      logic                  write_enable;
      logic [SIZE_WIDTH-1:0] write_address;
      logic [7:0]            write_byte;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_WIDTH-1:0] min_image_size;
      logic [SIZE_WIDTH-1:0] max_image_size;
   } cfg_type;

endpackage

### rtl/firmware_upload_session_checker.sv
// Firmware upload session checker: top level with input and result registers
// and the APB-style register port. Depends on fusc_pkg and fusc_session.
//
// Use: items enter on req_valid/req_ready with payload req_data (kind, value,
// chunk_length, data_byte); one result per item of kind 0..4 leaves on
// rsp_valid/rsp_ready with payload rsp_data; kinds 5..7 are taken and give none.
// A transfer is taken into the input register; when that register advances,
// its item is checked against the session state and its result is loaded into
// the result register. One item per cycle is sustained: the input register
// advances whenever the result register is empty or being taken.
// When the receiver stalls, the result register holds and the input register
// holds one more item, after which req_ready falls.
// Reset (synchronous, active high) empties both registers, closes any session
// and sets min_image_size to 0x10000 and max_image_size to 0x100000.
// Registers: min_image_size at byte address 0, max_image_size at 4; write them
// only while no item is in flight.
`timescale 1ns / 1ps

module firmware_upload_session_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  fusc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fusc_pkg::rsp_type                     rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fusc_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam int unsigned SW = fusc_pkg::SIZE_WIDTH;

   logic              in_valid_ff, in_valid_in;
   fusc_pkg::req_type in_data_ff, in_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fusc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   fusc_pkg::cfg_type cfg_ff, cfg_in;

   logic              advance;
   logic              result_en;
   fusc_pkg::rsp_type result;
   logic              csr_write;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   fusc_session u_session (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_data_ff),
      .cfg       (cfg_ff),
      .result_en (result_en),
      .result    (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cfg_in       = cfg_ff;

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (advance) begin
         rsp_valid_in = result_en;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         case (paddr[2])
            fusc_pkg::CSR_MIN_IMAGE_SIZE: cfg_in.min_image_size = pwdata[SW-1:0];
            fusc_pkg::CSR_MAX_IMAGE_SIZE: cfg_in.max_image_size = pwdata[SW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         fusc_pkg::CSR_MIN_IMAGE_SIZE: prdata = 32'(cfg_ff.min_image_size);
         fusc_pkg::CSR_MAX_IMAGE_SIZE: prdata = 32'(cfg_ff.max_image_size);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff               <= 1'b0;
         rsp_valid_ff              <= 1'b0;
         cfg_ff.min_image_size     <= fusc_pkg::MIN_SIZE_RESET;
         cfg_ff.max_image_size     <= fusc_pkg::MAX_SIZE_RESET;
      end else begin
         in_valid_ff               <= in_valid_in;
         rsp_valid_ff              <= rsp_valid_in;
         cfg_ff                    <= cfg_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_write_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.write_enable) |->
      (rsp_data_ff.status == 4'(fusc_pkg::ST_BYTE_OK) ||
       rsp_data_ff.status == 4'(fusc_pkg::ST_CHUNK_OK)))
      else $error("flash write with a non-byte status");

   a_unknown_kind_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.kind > 3'(fusc_pkg::KIND_ABORT)) |=> !rsp_valid_ff)
      else $error("result produced for an unknown kind");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while both registers are full");

endmodule

### rtl/fusc_crc_byte.sv
// Byte-wide reflected CRC-32 update, eight bit steps unrolled.
// Depends on fusc_pkg for the polynomial.
`timescale 1ns / 1ps

module fusc_crc_byte (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] acc;
      acc = crc_cur ^ {24'd0, data_byte};
      for (int i = 0; i < 8; i++) begin
         acc = (acc >> 1) ^ (fusc_pkg::CRC_POLY & {32{acc[0]}});
      end
      crc_next = acc;
   end

endmodule

### rtl/fusc_session.sv
// Session state registers and the per-item check and update logic.
// Depends on fusc_pkg and fusc_crc_byte.
`timescale 1ns / 1ps

module fusc_session (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  fusc_pkg::req_type item,
   input  fusc_pkg::cfg_type cfg,
   output logic              result_en,
   output fusc_pkg::rsp_type result
);

   localparam int unsigned SW = fusc_pkg::SIZE_WIDTH;
   localparam int unsigned LW = fusc_pkg::LEN_WIDTH;

   logic          session_active_ff, session_active_in;
   logic [SW-1:0] expected_size_ff, expected_size_in;
   logic [SW-1:0] received_count_ff, received_count_in;
   logic [31:0]   crc_committed_ff, crc_committed_in;
   logic [31:0]   crc_working_ff, crc_working_in;
   logic          chunk_open_ff, chunk_open_in;
   logic [LW-1:0] chunk_remaining_ff, chunk_remaining_in;
   logic [LW-1:0] chunk_written_ff, chunk_written_in;

   logic [31:0]   crc_byte_next;
   logic [LW-1:0] written_inc;
   logic [LW-1:0] remaining_dec;
   logic [SW:0]   chunk_end;
   logic [31:0]   crc_result;

   fusc_crc_byte u_crc (
      .crc_cur   (crc_working_ff),
      .data_byte (item.data_byte),
      .crc_next  (crc_byte_next)
   );

   assign written_inc   = chunk_written_ff + LW'(1);
   assign remaining_dec = chunk_remaining_ff - LW'(1);
   assign chunk_end     = {1'b0, received_count_ff} + (SW + 1)'(item.chunk_length);
   assign crc_result    = ~crc_committed_ff;

   always_comb begin
      session_active_in  = session_active_ff;
      expected_size_in   = expected_size_ff;
      received_count_in  = received_count_ff;
      crc_committed_in   = crc_committed_ff;
      crc_working_in     = crc_working_ff;
      chunk_open_in      = chunk_open_ff;
      chunk_remaining_in = chunk_remaining_ff;
      chunk_written_in   = chunk_written_ff;
      result_en          = 1'b0;
      result             = '0;

      if (step && (item.kind <= 3'(fusc_pkg::KIND_ABORT))) begin
         result_en = 1'b1;
         // drop an open chunk on any non-byte item of a known kind
         if (item.kind != 3'(fusc_pkg::KIND_BYTE)) begin
            chunk_open_in      = 1'b0;
            chunk_remaining_in = '0;
            chunk_written_in   = '0;
            crc_working_in     = crc_committed_ff;
         end
         case (item.kind)
            3'(fusc_pkg::KIND_BEGIN): begin
               session_active_in = 1'b0;
               expected_size_in  = '0;
               received_count_in = '0;
               crc_committed_in  = fusc_pkg::CRC_INIT;
               crc_working_in    = fusc_pkg::CRC_INIT;
               if ((item.value < 32'(cfg.min_image_size)) ||
                   (item.value > 32'(cfg.max_image_size))) begin
                  result.status = 4'(fusc_pkg::ST_SIZE);
               end else begin
                  session_active_in = 1'b1;
                  expected_size_in  = item.value[SW-1:0];
                  result.status     = 4'(fusc_pkg::ST_BEGIN_OK);
               end
            end
            3'(fusc_pkg::KIND_HEADER): begin
               if (!session_active_ff) begin
                  result.status = 4'(fusc_pkg::ST_NOBEGIN);
               end else if (item.value != 32'(received_count_ff)) begin
                  result.status       = 4'(fusc_pkg::ST_OFFSET);
                  result.report_value = 32'(received_count_ff);
               end else if ((item.chunk_length == '0) ||
                            (item.chunk_length > LW'(fusc_pkg::CHUNK_MAX))) begin
                  result.status = 4'(fusc_pkg::ST_LENGTH);
               end else if (chunk_end > {1'b0, expected_size_ff}) begin
                  result.status = 4'(fusc_pkg::ST_OVERFLOW);
               end else begin
                  chunk_open_in      = 1'b1;
                  chunk_remaining_in = item.chunk_length;
                  chunk_written_in   = '0;
                  result.status      = 4'(fusc_pkg::ST_BYTE_OK);
               end
            end
            3'(fusc_pkg::KIND_BYTE): begin
               if (!chunk_open_ff) begin
                  result.status = 4'(fusc_pkg::ST_STRAY);
               end else begin
                  result.write_enable  = 1'b1;
                  result.write_address = received_count_ff + SW'(chunk_written_ff);
                  result.write_byte    = item.data_byte;
                  crc_working_in       = crc_byte_next;
                  chunk_written_in     = written_inc;
                  chunk_remaining_in   = remaining_dec;
                  if (remaining_dec == '0) begin
                     received_count_in   = received_count_ff + SW'(written_inc);
                     crc_committed_in    = crc_byte_next;
                     chunk_open_in       = 1'b0;
                     chunk_written_in    = '0;
                     result.status       = 4'(fusc_pkg::ST_CHUNK_OK);
                     result.report_value = 32'(received_count_ff + SW'(written_inc));
                  end else begin
                     result.status = 4'(fusc_pkg::ST_BYTE_OK);
                  end
               end
            end
            3'(fusc_pkg::KIND_END): begin
               if (!session_active_ff) begin
                  result.status = 4'(fusc_pkg::ST_NOBEGIN);
               end else if (received_count_ff != expected_size_ff) begin
                  result.status       = 4'(fusc_pkg::ST_INCOMPLETE);
                  result.report_value = 32'(received_count_ff);
               end else begin
                  if (crc_result != item.value) begin
                     result.status       = 4'(fusc_pkg::ST_CRC);
                     result.report_value = crc_result;
                  end else begin
                     result.status = 4'(fusc_pkg::ST_COMPLETE);
                  end
                  session_active_in = 1'b0;
                  expected_size_in  = '0;
                  received_count_in = '0;
                  crc_committed_in  = fusc_pkg::CRC_INIT;
                  crc_working_in    = fusc_pkg::CRC_INIT;
               end
            end
            3'(fusc_pkg::KIND_ABORT): begin
               session_active_in = 1'b0;
               expected_size_in  = '0;
               received_count_in = '0;
               crc_committed_in  = fusc_pkg::CRC_INIT;
               crc_working_in    = fusc_pkg::CRC_INIT;
               result.status     = 4'(fusc_pkg::ST_ABORTED);
            end
            default: begin
               result_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         session_active_ff  <= 1'b0;
         expected_size_ff   <= '0;
         received_count_ff  <= '0;
         crc_committed_ff   <= fusc_pkg::CRC_INIT;
         crc_working_ff     <= fusc_pkg::CRC_INIT;
         chunk_open_ff      <= 1'b0;
         chunk_remaining_ff <= '0;
         chunk_written_ff   <= '0;
      end else begin
         session_active_ff  <= session_active_in;
         expected_size_ff   <= expected_size_in;
         received_count_ff  <= received_count_in;
         crc_committed_ff   <= crc_committed_in;
         crc_working_ff     <= crc_working_in;
         chunk_open_ff      <= chunk_open_in;
         chunk_remaining_ff <= chunk_remaining_in;
         chunk_written_ff   <= chunk_written_in;
      end
   end

   a_chunk_in_session: assert property (@(posedge clock) disable iff (reset)
      chunk_open_ff |-> session_active_ff)
      else $error("chunk open without an active session");

   a_count_in_bounds: assert property (@(posedge clock) disable iff (reset)
      session_active_ff |-> (received_count_ff <= expected_size_ff))
      else $error("received count beyond expected size");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !session_active_ff |-> (received_count_ff == '0 &&
                              crc_committed_ff == fusc_pkg::CRC_INIT))
      else $error("idle session holds stale count or CRC");

endmodule

### tb/sv/tb.sv
// Testbench for the firmware upload session checker: drives upload sessions,
// stray and malformed items and register settings, and checks every result.
// Depends on fusc_pkg and firmware_upload_session_checker.
`timescale 1ns / 1ps

module tb;
   import fusc_pkg::*;

   class upload_session_tracker;
      logic [SIZE_WIDTH-1:0] min_size;
      logic [SIZE_WIDTH-1:0] max_size;
      bit                    active;
      logic [SIZE_WIDTH-1:0] exp_size;
      logic [SIZE_WIDTH-1:0] recv_count;
      logic [31:0]           crc_done;
      logic [31:0]           crc_run;
      bit                    chunk_open;
      logic [LEN_WIDTH-1:0]  chunk_left;
      logic [LEN_WIDTH-1:0]  chunk_count;
      rsp_type               due_results[$];
      int                    errors;
      int                    checked;
      int                    completed;
      int                    crc_fails;

      function new();
         min_size = MIN_SIZE_RESET;
         max_size = MAX_SIZE_RESET;
         clear_session();
      endfunction

      function void clear_session();
         active      = 1'b0;
         exp_size    = '0;
         recv_count  = '0;
         crc_done    = CRC_INIT;
         crc_run     = CRC_INIT;
         chunk_open  = 1'b0;
         chunk_left  = '0;
         chunk_count = '0;
      endfunction

      function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic [31:0] x;
         x = c ^ {24'h0, b};
         for (int i = 0; i < 8; i++) begin
            if (x[0]) x = (x >> 1) ^ CRC_POLY;
            else      x = x >> 1;
         end
         return x;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      function int pending();
         return due_results.size();
      endfunction

      function void take_item(req_type it);
         rsp_type r;
         r = '0;
         if (it.kind > KIND_ABORT) return;
         if (it.kind != KIND_BYTE && chunk_open) begin
            chunk_open  = 1'b0;
            chunk_left  = '0;
            chunk_count = '0;
            crc_run     = crc_done;
         end
         case (it.kind)
            KIND_BEGIN: begin
               clear_session();
               if (it.value < 32'(min_size) || it.value > 32'(max_size)) begin
                  r.status = ST_SIZE;
               end else begin
                  active   = 1'b1;
                  exp_size = it.value[SIZE_WIDTH-1:0];
                  r.status = ST_BEGIN_OK;
               end
            end
            KIND_HEADER: begin
               if (!active) begin
                  r.status = ST_NOBEGIN;
               end else if (it.value != {8'h00, recv_count}) begin
                  r.status       = ST_OFFSET;
                  r.report_value = {8'h00, recv_count};
               end else if (it.chunk_length == '0 ||
                            it.chunk_length > LEN_WIDTH'(CHUNK_MAX)) begin
                  r.status = ST_LENGTH;
               end else if (({1'b0, recv_count} + 25'(it.chunk_length))
                            > {1'b0, exp_size}) begin
                  r.status = ST_OVERFLOW;
               end else begin
                  chunk_open  = 1'b1;
                  chunk_left  = it.chunk_length;
                  chunk_count = '0;
                  crc_run     = crc_done;
                  r.status    = ST_BYTE_OK;
               end
            end
            KIND_BYTE: begin
               if (!chunk_open) begin
                  r.status = ST_STRAY;
               end else begin
                  r.write_enable  = 1'b1;
                  r.write_address = recv_count + SIZE_WIDTH'(chunk_count);
                  r.write_byte    = it.data_byte;
                  crc_run         = crc_step(crc_run, it.data_byte);
                  chunk_count     = chunk_count + LEN_WIDTH'(1);
                  chunk_left      = chunk_left - LEN_WIDTH'(1);
                  if (chunk_left == '0) begin
                     recv_count     = recv_count + SIZE_WIDTH'(chunk_count);
                     crc_done       = crc_run;
                     chunk_open     = 1'b0;
                     chunk_count    = '0;
                     r.status       = ST_CHUNK_OK;
                     r.report_value = {8'h00, recv_count};
                  end else begin
                     r.status = ST_BYTE_OK;
                  end
               end
            end
            KIND_END: begin
               if (!active) begin
                  r.status = ST_NOBEGIN;
               end else if (recv_count != exp_size) begin
                  r.status       = ST_INCOMPLETE;
                  r.report_value = {8'h00, recv_count};
               end else begin
                  if (~crc_done != it.value) begin
                     r.status       = ST_CRC;
                     r.report_value = ~crc_done;
                  end else begin
                     r.status = ST_COMPLETE;
                  end
                  clear_session();
               end
            end
            default: begin
               clear_session();
               r.status = ST_ABORTED;
            end
         endcase
         due_results.push_back(r);
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("result with status %0d and nothing pending",
                                      got.status));
            return;
         end
         want = due_results.pop_front();
         checked++;
         if (got.status != want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.report_value != want.report_value)
            report_mismatch($sformatf("report_value %h, want %h (status %0d)",
                                      got.report_value, want.report_value, want.status));
         if (got.write_enable != want.write_enable)
            report_mismatch($sformatf("write_enable %b, want %b",
                                      got.write_enable, want.write_enable));
         if (got.write_address != want.write_address)
            report_mismatch($sformatf("write_address %h, want %h",
                                      got.write_address, want.write_address));
         if (got.write_byte != want.write_byte)
            report_mismatch($sformatf("write_byte %h, want %h",
                                      got.write_byte, want.write_byte));
         if (want.status == ST_COMPLETE) completed++;
         if (want.status == ST_CRC) crc_fails++;
      endtask
   endclass

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      psel      = 1'b0;
   logic                      penable   = 1'b0;
   logic                      pwrite    = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr     = '0;
   logic [31:0]               pwdata    = '0;
   logic [31:0]               prdata;
   logic                      pready;

   upload_session_tracker sb = new();
   int  items_sent;
   int  settings_used;
   int  rsp_wait;
   bit  send_calm;
   bit  recv_calm;

   firmware_upload_session_checker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("Timeout with %0d results outstanding", sb.pending());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int draw_gap(ref bit calm);
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   // take results, stalling at random between transfers
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
            rsp_wait = draw_gap(recv_calm);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   function automatic req_type make_item(logic [2:0] k, logic [31:0] v,
                                         logic [LEN_WIDTH-1:0] n, logic [7:0] b);
      req_type it;
      it.kind         = k;
      it.value        = v;
      it.chunk_length = n;
      it.data_byte    = b;
      return it;
   endfunction

   function automatic req_type noise_item();
      return make_item(3'($urandom_range(0, 7)), $urandom, LEN_WIDTH'($urandom),
                       8'($urandom));
   endfunction

   task automatic send_item(input req_type it);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      sb.take_item(it);
      items_sent++;
   endtask

   // hold off until every result is in, then let the pipeline drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [SIZE_WIDTH-1:0] v);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {8'($urandom), v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_MIN_IMAGE_SIZE) sb.min_size = v;
      else                           sb.max_size = v;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got != {8'h00, v})
         sb.report_mismatch($sformatf("register %0d reads %h, want %h", idx, got, v));
   endtask

   task automatic set_limits(input logic [SIZE_WIDTH-1:0] lo, input logic [SIZE_WIDTH-1:0] hi);
      write_csr(CSR_MIN_IMAGE_SIZE, lo);
      write_csr(CSR_MAX_IMAGE_SIZE, hi);
      settings_used++;
   endtask

   task automatic run_session(input int unsigned size_cap);
      int unsigned lo, hi, size, left, len, first;
      logic [31:0] crc_val;
      first = items_sent;
      lo    = 32'(sb.min_size);
      hi    = 32'(sb.max_size);
      if (hi > lo + size_cap) hi = lo + size_cap;
      size = (lo <= hi) ? $urandom_range(hi, lo) : lo;
      if ($urandom_range(0, 9) == 0) send_item(make_item(KIND_BEGIN, $urandom, '0, '0));
      else send_item(make_item(KIND_BEGIN, size, '0, '0));
      while (sb.active && sb.recv_count < sb.exp_size && items_sent - first < 400) begin
         left = 32'(sb.exp_size - sb.recv_count);
         len  = $urandom_range(1, left < 24 ? left : 24);
         if ($urandom_range(0, 7) == 0) len = $urandom_range(1, left < 1024 ? left : 1024);
         case ($urandom_range(0, 19))
            0: send_item(make_item(KIND_HEADER,
                                   32'(sb.recv_count) + 1 + $urandom_range(0, 9),
                                   LEN_WIDTH'(len), '0));
            1: send_item(make_item(KIND_HEADER, 32'(sb.recv_count),
                                   ($urandom_range(0, 1) ? '0 :
                                    LEN_WIDTH'($urandom_range(CHUNK_MAX + 1, 2047))), '0));
            2: send_item(make_item(KIND_HEADER, 32'(sb.recv_count),
                                   LEN_WIDTH'(left + $urandom_range(1, 8)), '0));
            3: send_item(noise_item());
            4: send_item(make_item(KIND_END, $urandom, '0, '0));
            5: if ($urandom_range(0, 3) == 0) send_item(make_item(KIND_ABORT, $urandom, '0, '0));
            default: begin
               send_item(make_item(KIND_HEADER, 32'(sb.recv_count), LEN_WIDTH'(len), '0));
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 49) == 0) begin
                     send_item(noise_item());
                     if ($urandom_range(0, 1))
                        send_item(make_item(KIND_BYTE, $urandom, '0, 8'($urandom)));
                     break;
                  end
                  send_item(make_item(KIND_BYTE, $urandom, LEN_WIDTH'($urandom),
                                      8'($urandom)));
               end
            end
         endcase
      end
      if (sb.active && sb.recv_count == sb.exp_size) begin
         crc_val = ~sb.crc_done;
         if ($urandom_range(0, 7) == 0) crc_val[$urandom_range(0, 31)] ^= 1'b1;
         send_item(make_item(KIND_END, crc_val, LEN_WIDTH'($urandom), 8'($urandom)));
      end else if (sb.active && $urandom_range(0, 1)) begin
         send_item(make_item(KIND_ABORT, '0, '0, '0));
      end
   endtask

   initial begin
      int unsigned lo, hi, stop_at, phase_end;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limits: idle errors, ignored kinds, size bounds, header checks
      send_item(make_item(KIND_ABORT, '0, '0, '0));
      send_item(make_item(KIND_HEADER, '0, 11'd1, '0));
      send_item(make_item(KIND_END, '0, '0, '0));
      send_item(make_item(KIND_BYTE, '1, '1, 8'hFF));
      send_item(make_item(3'd5, '1, '1, 8'hFF));
      send_item(make_item(3'd7, '1, '1, 8'hFF));
      send_item(make_item(KIND_BEGIN, '0, '0, '0));
      send_item(make_item(KIND_BEGIN, '1, '1, '1));
      send_item(make_item(KIND_BEGIN, 32'h0010_0001, '0, '0));
      send_item(make_item(KIND_BEGIN, 32'h0001_0000, '0, '0));
      send_item(make_item(KIND_HEADER, 32'd5, 11'd4, '0));
      send_item(make_item(KIND_HEADER, '0, '0, '0));
      send_item(make_item(KIND_HEADER, '0, 11'd1025, '0));
      send_item(make_item(KIND_HEADER, '0, '1, '0));
      send_item(make_item(KIND_HEADER, '0, 11'(CHUNK_MAX), '0));
      send_item(make_item(KIND_BYTE, '0, '0, 8'h00));
      send_item(make_item(KIND_BYTE, '0, '0, 8'hA5));
      send_item(make_item(KIND_END, '0, '0, '0));
      send_item(make_item(KIND_BYTE, '0, '0, 8'h3C));
      send_item(make_item(KIND_BEGIN, 32'h0010_0000, '0, '0));
      wait_idle();

      // tiny images: overflow, chunk commit, CRC failure, empty image
      set_limits('0, 24'd3);
      send_item(make_item(KIND_BEGIN, 32'd3, '0, '0));
      send_item(make_item(KIND_HEADER, '0, 11'd4, '0));
      send_item(make_item(KIND_HEADER, '0, 11'd2, '0));
      send_item(make_item(KIND_BYTE, '0, '0, 8'h12));
      send_item(make_item(KIND_BYTE, '0, '0, 8'hFF));
      send_item(make_item(KIND_HEADER, 32'd2, 11'd1, '0));
      send_item(make_item(KIND_BYTE, '0, '0, 8'h80));
      send_item(make_item(KIND_END, 32'hDEAD_BEEF, '0, '0));
      send_item(make_item(KIND_BEGIN, '0, '0, '0));
      send_item(make_item(KIND_END, '0, '0, '0));
      send_item(make_item(KIND_BEGIN, 32'd1, '0, '0));
      send_item(make_item(KIND_ABORT, '0, '0, '0));
      wait_idle();

      stop_at = items_sent + 1100;
      set_limits('0, '1);
      while (items_sent < stop_at) begin
         phase_end = items_sent + 150;
         while (items_sent < phase_end && items_sent < stop_at)
            run_session($urandom_range(0, 7) == 0 ? 300 : 60);
         wait_idle();
         case ($urandom_range(0, 4))
            0: set_limits('0, '1);
            1: begin
               lo = $urandom_range(0, 40);
               set_limits(SIZE_WIDTH'(lo), SIZE_WIDTH'(lo));
            end
            2: set_limits(SIZE_WIDTH'($urandom_range(20, 60)),
                          SIZE_WIDTH'($urandom_range(0, 19)));
            3: begin
               lo = $urandom_range(0, 10);
               set_limits(SIZE_WIDTH'(lo), SIZE_WIDTH'(lo + $urandom_range(0, 120)));
            end
            default: begin
               lo = $urandom_range(0, 30);
               hi = $urandom_range(lo, 400);
               set_limits(SIZE_WIDTH'(lo), SIZE_WIDTH'(hi));
            end
         endcase
      end
      wait_idle();

      $display("Sent %0d items under %0d register settings; checked %0d results,",
               items_sent, settings_used, sb.checked);
      $display("including %0d completed sessions and %0d CRC rejections.",
               sb.completed, sb.crc_fails);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
